// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the hasher modules.
// Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SHAMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define SHAMH_NEVER(lbl, cond) `SHAMH_ASSERT(lbl, !(cond))

`endif

// ===== hdl/shamh_pkg.sv =====
package shamh_pkg;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        msg_last;
  } msg_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } digest_out_t;

  // one padded message word on its way to the round engine
  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;
  } queue_entry_t;

  typedef struct packed {
    logic         push;
    queue_entry_t entry;
  } queue_push_t;

  typedef enum logic [2:0] {
    FS_IN,
    FS_MARK,
    FS_ZERO,
    FS_LEN_HI,
    FS_LEN_LO
  } front_state_e;

  typedef enum logic [1:0] {
    CS_ROUND,
    CS_ADD,
    CS_OUT
  } core_state_e;

  localparam logic [31:0] PAD_MARK    = 32'h8000_0000;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [3:0]  LEN_SLOT    = 4'd14;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [5:0]  LAST_LOAD   = 6'd15;
  localparam logic [2:0]  LAST_DIGEST = 3'd7;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    logic [63:0] xx;
    xx = {x, x} >> n;
    return xx[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hdl/shamh_front.sv =====
module shamh_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  shamh_pkg::msg_in_t    in_word_i,
  input  logic                  q_full_i,
  output shamh_pkg::queue_push_t q_push_o
);
  import shamh_pkg::*;

  front_state_e state_q, state_d;
  logic [3:0]   fill_q, fill_d;
  logic [60:0]  total_q, total_d;
  logic [2:0]   nbytes;
  logic [31:0]  packed_word;
  logic         accept;
  logic [3:0]   fill_inc;

  always_comb begin
    if (!in_word_i.msg_last || (in_word_i.valid_bytes inside {[3'd4:3'd7]})) begin
      nbytes = FULL_BYTES;
    end else begin
      nbytes = in_word_i.valid_bytes;
    end
  end

  // mask unused bytes; a short last word carries its own pad byte
  always_comb begin
    case (nbytes)
      3'd0:    packed_word = PAD_MARK;
      3'd1:    packed_word = {in_word_i.msg_word[31:24], PAD_BYTE, 16'h0};
      3'd2:    packed_word = {in_word_i.msg_word[31:16], PAD_BYTE, 8'h0};
      3'd3:    packed_word = {in_word_i.msg_word[31:8], PAD_BYTE};
      default: packed_word = in_word_i.msg_word;
    endcase
  end

  assign fill_inc = fill_q + 4'd1;
  assign accept   = in_valid_i && !in_stall_o;

  // outputs
  always_comb begin
    in_stall_o           = (state_q != FS_IN) || q_full_i;
    q_push_o.push        = 1'b0;
    q_push_o.entry.word  = '0;
    q_push_o.entry.msg_end = 1'b0;
    case (state_q)
      FS_IN: begin
        q_push_o.push       = accept;
        q_push_o.entry.word = packed_word;
      end
      FS_MARK: begin
        q_push_o.push       = !q_full_i;
        q_push_o.entry.word = PAD_MARK;
      end
      FS_ZERO: begin
        q_push_o.push = !q_full_i;
      end
      FS_LEN_HI: begin
        q_push_o.push       = !q_full_i;
        q_push_o.entry.word = total_q[60:29];
      end
      FS_LEN_LO: begin
        q_push_o.push          = !q_full_i;
        q_push_o.entry.word    = {total_q[28:0], 3'b000};
        q_push_o.entry.msg_end = 1'b1;
      end
      default: begin
        q_push_o.push = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IN: begin
        if (accept && in_word_i.msg_last) begin
          if (nbytes == FULL_BYTES) begin
            state_d = FS_MARK;
          end else if (fill_inc == LEN_SLOT) begin
            state_d = FS_LEN_HI;
          end else begin
            state_d = FS_ZERO;
          end
        end
      end
      FS_MARK, FS_ZERO: begin
        if (!q_full_i) begin
          state_d = (fill_inc == LEN_SLOT) ? FS_LEN_HI : FS_ZERO;
        end
      end
      FS_LEN_HI: begin
        if (!q_full_i) begin
          state_d = FS_LEN_LO;
        end
      end
      FS_LEN_LO: begin
        if (!q_full_i) begin
          state_d = FS_IN;
        end
      end
      default: state_d = FS_IN;
    endcase
  end

  // counters
  always_comb begin
    fill_d  = q_push_o.push ? fill_inc : fill_q;
    total_d = total_q;
    if (accept) begin
      total_d = total_q + 61'(nbytes);
    end
    if (state_q == FS_LEN_LO && !q_full_i) begin
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IN;
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

endmodule

// ===== hdl/shamh_queue.sv =====
`include "assert_macros.svh"

module shamh_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  shamh_pkg::queue_push_t  push_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output shamh_pkg::queue_entry_t head_o
);
  import shamh_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  queue_entry_t    mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `SHAMH_NEVER(no_overflow_a, push_i.push && full_o)
  `SHAMH_ASSERT(count_bound_a, count_q <= CntW'(DEPTH))

endmodule

// ===== hdl/shamh_core.sv =====
`include "assert_macros.svh"

module shamh_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  shamh_pkg::queue_entry_t q_head_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output shamh_pkg::digest_out_t  out_word_o
);
  import shamh_pkg::*;

  core_state_e state_q, state_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  logic        done_q, done_d;
  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];
  logic [31:0] vars_q [8];
  logic [31:0] vars_d [8];
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic        loading, step, out_take;
  logic [31:0] w, t1, t2, ch, maj;

  assign loading  = (round_q[5:4] == 2'b00);
  assign out_take = (state_q == CS_OUT) && !out_stall_i;

  // outputs
  always_comb begin
    q_pop_o                 = 1'b0;
    out_valid_o             = 1'b0;
    step                    = 1'b0;
    out_word_o.digest_word  = hash_q[idx_q];
    out_word_o.digest_index = idx_q;
    out_word_o.digest_last  = (idx_q == LAST_DIGEST);
    case (state_q)
      CS_ROUND: begin
        q_pop_o = loading && !q_empty_i;
        step    = !loading || !q_empty_i;
      end
      CS_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_ROUND: begin
        if (step && round_q == LAST_ROUND) begin
          state_d = CS_ADD;
        end
      end
      CS_ADD: begin
        state_d = done_q ? CS_OUT : CS_ROUND;
      end
      CS_OUT: begin
        if (out_take && idx_q == LAST_DIGEST) begin
          state_d = CS_ROUND;
        end
      end
      default: state_d = CS_ROUND;
    endcase
  end

  // schedule word and round function
  always_comb begin
    if (loading) begin
      w = q_head_i.word;
    end else begin
      w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    end
    ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
    maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
    t1  = vars_q[7] + big_sigma1(vars_q[4]) + ch + round_k(round_q) + w;
    t2  = big_sigma0(vars_q[0]) + maj;
  end

  always_comb begin
    round_d = round_q;
    idx_d   = idx_q;
    done_d  = done_q;
    hash_d  = hash_q;
    vars_d  = vars_q;
    win_d   = win_q;
    case (state_q)
      CS_ROUND: begin
        if (step) begin
          round_d = round_q + 6'd1;
          for (int i = 0; i < 15; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[15] = w;
          vars_d[0] = t1 + t2;
          vars_d[1] = vars_q[0];
          vars_d[2] = vars_q[1];
          vars_d[3] = vars_q[2];
          vars_d[4] = vars_q[3] + t1;
          vars_d[5] = vars_q[4];
          vars_d[6] = vars_q[5];
          vars_d[7] = vars_q[6];
          if (round_q == LAST_LOAD) begin
            done_d = q_head_i.msg_end;
          end
        end
      end
      CS_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + vars_q[i];
          vars_d[i] = hash_q[i] + vars_q[i];
        end
      end
      CS_OUT: begin
        if (out_take) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_DIGEST) begin
            done_d = 1'b0;
            hash_d = HASH_INIT;
            vars_d = HASH_INIT;
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_ROUND;
      round_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
      hash_q  <= HASH_INIT;
      vars_q  <= HASH_INIT;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      hash_q  <= hash_d;
      vars_q  <= vars_d;
    end
  end

  `SHAMH_ASSERT(round_only_a, (round_q != 6'd0) |-> (state_q == CS_ROUND))
  `SHAMH_ASSERT(hash_reinit_a, (out_take && idx_q == LAST_DIGEST) |=> (hash_q[0] == HASH_INIT[0]))

endmodule

// ===== hdl/sha256_message_hasher.sv =====
// SHA-256 hasher over a stream of big-endian 32-bit message words.
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per accept,
// valid_bytes below four only on the word flagged msg_last.
// Output channel (out_valid_o / out_stall_i / out_word_o): eight digest
// words, index 0 first, digest_last on index 7.
// The front pads the message (0x80 mark, zeros, 64-bit bit length) and
// feeds a short word queue; input is stalled while padding is pushed
// (up to 18 words after the last one) or while the queue is full.
// The round engine runs one SHA-256 round per cycle: rounds 0..15 take
// one queued word each and wait while the queue is empty, 16..63 use the
// rolling schedule; an add step then adds the working variables into the
// hash. After the last block's add the digest is output one word per
// cycle while out_stall_i is low.
// A stalled digest word is held unchanged; the engine waits and the queue
// keeps filling meanwhile. After the eighth word the hash returns to its
// initial values for the next message.
// Reset: asynchronous, active low; hash set to the initial values, queue
// and counters cleared.
module sha256_message_hasher #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  shamh_pkg::msg_in_t     in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output shamh_pkg::digest_out_t out_word_o
);
  import shamh_pkg::*;

  queue_push_t  q_push;
  queue_entry_t q_head;
  logic         q_full, q_empty, q_pop;

  shamh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push)
  );

  shamh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  shamh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
